@@ hdl/tlbr_pkg.sv @@
package tlbr_pkg;

    localparam int TLB_ENTRIES_DEF = 4;
    localparam int SLOT_W = 6;
    localparam int VPAGE_W = 20;
    localparam int PPAGE_W = 12;
    localparam int FLAGS_W = 4;
    localparam int TICK_W = 32;
    localparam int COUNT_W = 32;
    localparam int POLICY_W = 2;

    // policy codes
    localparam logic [POLICY_W-1:0] POLICY_LRU = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_LFU = 2'd2;

    // write command codes broadcast to the cells
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_LOAD_STAMP = 3'd2;
    localparam logic [2:0] OP_LOAD_COUNT = 3'd3;
    localparam logic [2:0] OP_SHIFT = 3'd4;

    typedef struct packed {
        logic [VPAGE_W-1:0] virtual_page;
        logic [PPAGE_W-1:0] physical_page;
        logic               entry_valid;
        logic               entry_read_only;
        logic               entry_used;
        logic               entry_dirty;
        logic [TICK_W-1:0]  now_tick;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_written;
        logic               evicted_valid;
        logic [VPAGE_W-1:0] evicted_virtual_page;
    } out_t;

    // flags: bit0 valid, bit1 read-only, bit2 use, bit3 dirty
    typedef struct packed {
        logic [VPAGE_W-1:0] vpage;
        logic [PPAGE_W-1:0] ppage;
        logic [FLAGS_W-1:0] flags;
        logic [TICK_W-1:0]  stamp;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // running search result handed from cell to cell
    typedef struct packed {
        logic               inv_found;
        logic [SLOT_W-1:0]  inv_idx;
        logic               have_min;
        logic [SLOT_W-1:0]  min_idx;
        logic [TICK_W-1:0]  min_val;
        logic [VPAGE_W-1:0] min_vpage;
        logic [VPAGE_W-1:0] head_vpage;
    } scan_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [SLOT_W-1:0]  idx;
        logic [VPAGE_W-1:0] vpage;
        logic [PPAGE_W-1:0] ppage;
        logic [FLAGS_W-1:0] flags;
        logic [TICK_W-1:0]  tick;
    } wr_cmd_t;

endpackage

@@ hdl/tlbr_cell.sv @@
module tlbr_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tok_in,
    input  tlbr_pkg::scan_t   scan_in,
    input  logic              use_count,
    output logic              tok_out,
    output tlbr_pkg::scan_t   scan_out,
    input  tlbr_pkg::wr_cmd_t cmd,
    input  tlbr_pkg::entry_t  shift_in,
    output tlbr_pkg::entry_t  entry_out
);

    localparam logic [tlbr_pkg::SLOT_W-1:0] MY_IDX = tlbr_pkg::SLOT_W'(CELL_INDEX);

    tlbr_pkg::entry_t entry_reg;
    tlbr_pkg::entry_t entry_next;
    tlbr_pkg::scan_t  scan_reg;
    tlbr_pkg::scan_t  scan_next;
    logic             tok_reg;
    logic [tlbr_pkg::TICK_W-1:0] metric;
    logic             hit;

    assign metric = use_count ? entry_reg.count : entry_reg.stamp;
    assign hit = (cmd.idx == MY_IDX);

    always_comb begin
        scan_next = scan_in;
        if (!scan_in.inv_found && !entry_reg.flags[0]) begin
            scan_next.inv_found = 1'b1;
            scan_next.inv_idx = MY_IDX;
        end
        // strict compare keeps ties on the lower index
        if (!scan_in.have_min || (metric < scan_in.min_val)) begin
            scan_next.have_min = 1'b1;
            scan_next.min_idx = MY_IDX;
            scan_next.min_val = metric;
            scan_next.min_vpage = entry_reg.vpage;
        end
        if (CELL_INDEX == 0) begin
            scan_next.head_vpage = entry_reg.vpage;
        end
    end

    always_comb begin
        entry_next = entry_reg;
        if (cmd.op == tlbr_pkg::OP_SHIFT) begin
            entry_next = shift_in;
        end else if (hit && (cmd.op != tlbr_pkg::OP_NONE)) begin
            entry_next.vpage = cmd.vpage;
            entry_next.ppage = cmd.ppage;
            entry_next.flags = cmd.flags;
            if (cmd.op == tlbr_pkg::OP_LOAD_STAMP) begin
                entry_next.stamp = cmd.tick;
            end
            if (cmd.op == tlbr_pkg::OP_LOAD_COUNT) begin
                entry_next.count = tlbr_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            tok_reg <= 1'b0;
        end else begin
            entry_reg <= entry_next;
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in) begin
            scan_reg <= scan_next;
        end
    end

    assign tok_out = tok_reg;
    assign scan_out = scan_reg;
    assign entry_out = entry_reg;

endmodule

@@ hdl/tlb_refill_replacement.sv @@
// channel  | ports             | payload
// ---------+-------------------+------------------------------------
// input    | s_valid, s_ready  | s_data  (tlbr_pkg::in_t), one refill
// result   | m_valid, m_ready  | m_data  (tlbr_pkg::out_t)
// config   | apb psel..pready  | policy_mode at byte address 0
//
// a refill search token walks the row of slot cells, one cell per cycle, and
// m_valid is registered once the token has passed the last cell.
// one refill is in flight at a time; s_ready drops until its result is taken.
// synchronous active-low reset clears all slots (all invalid) and the policy.
module tlb_refill_replacement #(
    parameter int TLB_ENTRIES = tlbr_pkg::TLB_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tlbr_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tlbr_pkg::out_t m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;
    localparam logic REG_POLICY_MODE = 1'b0;
    localparam logic [tlbr_pkg::SLOT_W-1:0] LAST_IDX = tlbr_pkg::SLOT_W'(TLB_ENTRIES - 1);

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [tlbr_pkg::POLICY_W-1:0]  policy_reg;
    tlbr_pkg::in_t                  in_reg;
    tlbr_pkg::out_t                 m_data_reg;
    tlbr_pkg::out_t                 result;
    logic                           m_valid_reg;
    logic                           accept;
    logic                           scan_done;
    logic                           cfg_write;
    tlbr_pkg::wr_cmd_t              cmd;
    tlbr_pkg::scan_t                scan_final;
    tlbr_pkg::entry_t               last_shift;

    logic [TLB_ENTRIES-1:0]         cell_tok;
    tlbr_pkg::scan_t                cell_scan [TLB_ENTRIES];
    tlbr_pkg::entry_t               cell_entry [TLB_ENTRIES];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign scan_done = cell_tok[TLB_ENTRIES-1];
    assign scan_final = cell_scan[TLB_ENTRIES-1];

    // last cell takes the new translation on a shift but keeps its stamp and count
    always_comb begin
        last_shift = cell_entry[TLB_ENTRIES-1];
        last_shift.vpage = in_reg.virtual_page;
        last_shift.ppage = in_reg.physical_page;
        last_shift.flags = {in_reg.entry_dirty, in_reg.entry_used,
                            in_reg.entry_read_only, in_reg.entry_valid};
    end

    genvar gi;
    generate
        for (gi = 0; gi < TLB_ENTRIES; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                tlbr_cell #(.CELL_INDEX(gi)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .tok_in    (accept),
                    .scan_in   ('0),
                    .use_count (policy_reg == tlbr_pkg::POLICY_LFU),
                    .tok_out   (cell_tok[gi]),
                    .scan_out  (cell_scan[gi]),
                    .cmd       (cmd),
                    .shift_in  ((TLB_ENTRIES > 1) ? cell_entry[(gi + 1) % TLB_ENTRIES]
                                                  : last_shift),
                    .entry_out (cell_entry[gi])
                );
            end else if (gi == TLB_ENTRIES - 1) begin : g_tail
                tlbr_cell #(.CELL_INDEX(gi)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .tok_in    (cell_tok[gi-1]),
                    .scan_in   (cell_scan[gi-1]),
                    .use_count (policy_reg == tlbr_pkg::POLICY_LFU),
                    .tok_out   (cell_tok[gi]),
                    .scan_out  (cell_scan[gi]),
                    .cmd       (cmd),
                    .shift_in  (last_shift),
                    .entry_out (cell_entry[gi])
                );
            end else begin : g_mid
                tlbr_cell #(.CELL_INDEX(gi)) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .tok_in    (cell_tok[gi-1]),
                    .scan_in   (cell_scan[gi-1]),
                    .use_count (policy_reg == tlbr_pkg::POLICY_LFU),
                    .tok_out   (cell_tok[gi]),
                    .scan_out  (cell_scan[gi]),
                    .cmd       (cmd),
                    .shift_in  (cell_entry[gi+1]),
                    .entry_out (cell_entry[gi])
                );
            end
        end
    endgenerate

    // victim decision once the token leaves the last cell
    always_comb begin
        cmd.op = tlbr_pkg::OP_NONE;
        cmd.idx = scan_final.inv_idx;
        cmd.vpage = in_reg.virtual_page;
        cmd.ppage = in_reg.physical_page;
        cmd.flags = {in_reg.entry_dirty, in_reg.entry_used,
                     in_reg.entry_read_only, in_reg.entry_valid};
        cmd.tick = in_reg.now_tick;
        result.slot_written = scan_final.inv_idx;
        result.evicted_valid = 1'b0;
        result.evicted_virtual_page = '0;
        if (scan_final.inv_found) begin
            cmd.op = tlbr_pkg::OP_LOAD;
        end else begin
            result.evicted_valid = 1'b1;
            unique case (policy_reg)
                tlbr_pkg::POLICY_FIFO: begin
                    cmd.op = tlbr_pkg::OP_SHIFT;
                    cmd.idx = LAST_IDX;
                    result.slot_written = LAST_IDX;
                    result.evicted_virtual_page = scan_final.head_vpage;
                end
                tlbr_pkg::POLICY_LFU: begin
                    cmd.op = tlbr_pkg::OP_LOAD_COUNT;
                    cmd.idx = scan_final.min_idx;
                    result.slot_written = scan_final.min_idx;
                    result.evicted_virtual_page = scan_final.min_vpage;
                end
                default: begin
                    cmd.op = tlbr_pkg::OP_LOAD_STAMP;
                    cmd.idx = scan_final.min_idx;
                    result.slot_written = scan_final.min_idx;
                    result.evicted_virtual_page = scan_final.min_vpage;
                end
            endcase
        end
        if (!((state_reg == ST_SCAN) && scan_done)) begin
            cmd.op = tlbr_pkg::OP_NONE;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_OUT;
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_SCAN) && scan_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        if ((state_reg == ST_SCAN) && scan_done) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // apb register file: one register, byte offset bits ignored
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= tlbr_pkg::POLICY_LRU;
        end else if (cfg_write && (paddr[2] == REG_POLICY_MODE)) begin
            policy_reg <= pwdata[tlbr_pkg::POLICY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_POLICY_MODE) ? {30'd0, policy_reg} : 32'd0;

endmodule
